// ----- design/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int CAP_W  = 5;
	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LIST   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic              do_insert;
		logic              do_remove;
		logic              do_rotate;
		logic              load_out;
		logic              take_front;
		logic [STAT_W-1:0] out_status;
		logic              out_last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic list_last;
	} stat_t;

endpackage
`default_nettype wire

// ----- design/spq_dp.sv -----
`default_nettype none
module spq_dp #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wen,
	input  wire logic        [spq_pkg::CAP_W-1:0]   cfg_wdata,
	input  wire logic signed [spq_pkg::DATA_W-1:0]  item_data,
	input  wire logic signed [spq_pkg::PRIO_W-1:0]  item_priority,
	input  wire spq_pkg::cmd_t                      cmd,
	output spq_pkg::stat_t                          stat,
	output logic         [spq_pkg::STAT_W-1:0]      status,
	output logic signed  [spq_pkg::DATA_W-1:0]      out_data,
	output logic signed  [spq_pkg::PRIO_W-1:0]      out_priority,
	output logic                                    last
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = $clog2(DEPTH);
	localparam int XW = (CW > CAP_W) ? CW : CAP_W;

	logic        [CAP_W-1:0]  capacity_q;
	logic        [CW-1:0]     count_q;
	logic        [KW-1:0]     list_idx_q;
	logic signed [DATA_W-1:0] data_q [DEPTH];
	logic signed [PRIO_W-1:0] prio_q [DEPTH];
	logic        [DEPTH-1:0]  ge;

	logic        [STAT_W-1:0] status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic signed [PRIO_W-1:0] out_prio_q;
	logic                     last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wen) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Live entry that stays ahead of the new request (ties keep arrival order)
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (CW'(i) < count_q) && (prio_q[i] >= item_priority);
		end
	end

	assign stat.empty     = (count_q == '0);
	assign stat.full      = (XW'(count_q) >= XW'(capacity_q)) || (count_q == CW'(DEPTH));
	assign stat.list_last = (CW'(list_idx_q) == (count_q - CW'(1)));

	generate
		for (genvar g = 0; g < DEPTH; g++) begin : g_cell
			logic signed [DATA_W-1:0] prev_data;
			logic signed [PRIO_W-1:0] prev_prio;
			logic                     prev_ge;
			logic signed [DATA_W-1:0] next_data;
			logic signed [PRIO_W-1:0] next_prio;

			if (g == 0) begin : g_head
				assign prev_data = item_data;
				assign prev_prio = item_priority;
				assign prev_ge   = 1'b1;
			end else begin : g_body
				assign prev_data = data_q[g-1];
				assign prev_prio = prio_q[g-1];
				assign prev_ge   = ge[g-1];
			end

			if (g == DEPTH - 1) begin : g_tail
				assign next_data = data_q[g];
				assign next_prio = prio_q[g];
			end else begin : g_inner
				assign next_data = data_q[g+1];
				assign next_prio = prio_q[g+1];
			end

			always_ff @(posedge clk) begin
				if (cmd.do_insert && (CW'(g) <= count_q) && !ge[g]) begin
					data_q[g] <= prev_ge ? item_data : prev_data;
					prio_q[g] <= prev_ge ? item_priority : prev_prio;
				end else if (cmd.do_remove) begin
					data_q[g] <= next_data;
					prio_q[g] <= next_prio;
				end else if (cmd.do_rotate && (CW'(g) < count_q)) begin
					// wrap the front to the back of the live range
					if (CW'(g) == count_q - CW'(1)) begin
						data_q[g] <= data_q[0];
						prio_q[g] <= prio_q[0];
					end else begin
						data_q[g] <= next_data;
						prio_q[g] <= next_prio;
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			list_idx_q <= '0;
		end else begin
			if (cmd.do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.do_remove) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.do_rotate) begin
				list_idx_q <= stat.list_last ? '0 : list_idx_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q   <= cmd.out_status;
			last_q     <= cmd.out_last;
			out_data_q <= cmd.take_front ? data_q[0] : '0;
			out_prio_q <= cmd.take_front ? prio_q[0] : '0;
		end
	end

	assign status       = status_q;
	assign out_data     = out_data_q;
	assign out_priority = out_prio_q;
	assign last         = last_q;

endmodule
`default_nettype wire

// ----- design/spq_ctrl.sv -----
`default_nettype none
module spq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [spq_pkg::MODE_W-1:0]  mode,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	input  wire spq_pkg::stat_t              stat,
	output spq_pkg::cmd_t                    cmd
);
	import spq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   can_load;

	assign can_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_stall = !can_load;
				if (in_valid && can_load) begin
					case (mode)
						MODE_INSERT: begin
							cmd.load_out   = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = stat.full ? ST_FULL : ST_OK;
							cmd.do_insert  = !stat.full;
						end
						MODE_REMOVE: begin
							cmd.load_out   = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = stat.empty ? ST_EMPTY : ST_OK;
							cmd.take_front = !stat.empty;
							cmd.do_remove  = !stat.empty;
						end
						MODE_LIST: begin
							if (stat.empty) begin
								cmd.load_out   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_status = ST_EMPTY;
							end else begin
								state_d = S_LIST;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LIST: begin
				if (can_load) begin
					cmd.load_out   = 1'b1;
					cmd.take_front = 1'b1;
					cmd.out_status = ST_OK;
					cmd.out_last   = stat.list_last;
					cmd.do_rotate  = 1'b1;
					if (stat.list_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
`default_nettype none
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   mode, item_data, item_priority
// result    out        out_valid / out_stall status, out_data, out_priority, last
// config    in         cfg_wen               cfg_wdata (capacity)
//
// For insert and remove the whole cell row compares and shifts in parallel,
// and the result lands in the output register.
// List first enters the list state, then gives one entry per cycle, while the
// result is not stalled, rotated through the front cell of the row.
// Reset clears the entry count, list index and output valid; capacity returns to 16.
// A stalled result holds the output register and, with it, all request handling.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_wen,
	input  wire logic        [spq_pkg::CAP_W-1:0]   cfg_wdata,
	// request channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic        [spq_pkg::MODE_W-1:0]  mode,
	input  wire logic signed [spq_pkg::DATA_W-1:0]  item_data,
	input  wire logic signed [spq_pkg::PRIO_W-1:0]  item_priority,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic         [spq_pkg::STAT_W-1:0]      status,
	output logic signed  [spq_pkg::DATA_W-1:0]      out_data,
	output logic signed  [spq_pkg::PRIO_W-1:0]      out_priority,
	output logic                                    last
);
	import spq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequence each request: decode, then walk the list one entry at a time
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the sorted cell row, the count, capacity and the result register
	spq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.item_data     (item_data),
		.item_priority (item_priority),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.out_data      (out_data),
		.out_priority  (out_priority),
		.last          (last)
	);

endmodule
`default_nettype wire

// ----- design/spq_checker.sv -----
`default_nettype none
module spq_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic        [spq_pkg::MODE_W-1:0]  mode,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic        [spq_pkg::STAT_W-1:0]  status,
	input wire logic signed [spq_pkg::DATA_W-1:0]  out_data,
	input wire logic                               last
);
	import spq_pkg::*;

	// Insert answers in the very next cycle with a single result
	a_insert_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode == MODE_INSERT) |=> out_valid && last)
		else $error("insert result missing");

	// A list keeps streaming: a taken non-final entry is followed at once
	a_list_stream: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("list stream broke");

	// No new request while a list is in flight
	a_list_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("request taken during list");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(status))
		else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.out_data  (out_data),
	.last      (last)
);
`default_nettype wire
